>>> rtl/blta_pkg.sv
// Shared types and constants for the block-linear texture address generator.
// Used by blta_geom and block_linear_texture_address; depends on nothing.
package blta_pkg;

    localparam int MAX_EXTENT_DEF = 16384;

    localparam int IMG_W   = 15;
    localparam int BLK_W   = 4;
    localparam int BPE_W   = 5;
    localparam int ALIGN_W = 17;
    localparam int LOG2_W  = 3;
    localparam int COORD_W = 14;
    localparam int ADDR_W  = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int GOB_BYTES      = 512;
    localparam int GOB_ROW_BYTES  = 64;
    localparam int GOB_ROWS       = 8;
    localparam int LIN_PITCH_ALIGN = 32;

    localparam logic [IMG_W-1:0]   RST_IMAGE_WIDTH  = IMG_W'(1);
    localparam logic [IMG_W-1:0]   RST_IMAGE_HEIGHT = IMG_W'(1);
    localparam logic [BLK_W-1:0]   RST_BLOCK_WIDTH  = BLK_W'(1);
    localparam logic [BLK_W-1:0]   RST_BLOCK_HEIGHT = BLK_W'(1);
    localparam logic [BPE_W-1:0]   RST_BPE          = BPE_W'(4);
    localparam logic               RST_TILE_MODE    = 1'b0;
    localparam logic [ALIGN_W-1:0] RST_ALIGN        = ALIGN_W'(512);
    localparam logic [LOG2_W-1:0]  RST_BH_LOG2      = LOG2_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH       = 3'd0,
        REG_IMAGE_HEIGHT      = 3'd1,
        REG_BLOCK_WIDTH       = 3'd2,
        REG_BLOCK_HEIGHT_PX   = 3'd3,
        REG_BYTES_PER_ELEMENT = 3'd4,
        REG_TILE_MODE         = 3'd5,
        REG_SURFACE_ALIGNMENT = 3'd6,
        REG_BLOCK_HEIGHT_LOG2 = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic               valid;
        logic               tile_mode;
        logic [LOG2_W-1:0]  bh_log2;
        logic [BPE_W-1:0]   bpe;
        logic [ADDR_W-1:0]  size;
    } geom_ctl_t;

endpackage

>>> rtl/blta_geom.sv
// Configuration registers and surface geometry sequencer (widths, pitch, size).
// Depends on blta_pkg; instantiated by block_linear_texture_address.
module blta_geom #(
    parameter int MAX_EXTENT = blta_pkg::MAX_EXTENT_DEF,
    localparam int NUM_W   = $clog2(MAX_EXTENT + 16),
    localparam int PITCH_W = NUM_W + 6,
    localparam int GOB_W   = NUM_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [blta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blta_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output blta_pkg::geom_ctl_t              ctl,
    output logic [NUM_W-1:0]                 width_blk,
    output logic [PITCH_W-1:0]               pitch,
    output logic [GOB_W-1:0]                 gobs_wide
);
    import blta_pkg::*;

    localparam int HAL_W = ((NUM_W > 10) ? NUM_W : 10) + 1;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_DIVW  = 7'b0000100,
        ST_DIVH  = 7'b0001000,
        ST_PITCH = 7'b0010000,
        ST_SIZE  = 7'b0100000,
        ST_ALIGN = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [IMG_W-1:0]     image_width_reg, image_height_reg;
    logic [BLK_W-1:0]     block_width_reg, block_height_reg;
    logic [BPE_W-1:0]     bpe_reg;
    logic                 tile_mode_reg;
    logic [ALIGN_W-1:0]   align_reg;
    logic [LOG2_W-1:0]    log2_reg;

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [3:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]     w_reg, w_next, h_reg, h_next;
    logic [PITCH_W-1:0]   pitch_reg, pitch_next;
    logic [GOB_W-1:0]     gobs_reg, gobs_next;
    logic [HAL_W-1:0]     hal_reg, hal_next;
    logic [ADDR_W-1:0]    prod_reg, prod_next;
    logic [ADDR_W-1:0]    size_reg, size_next;

    logic [BLK_W-1:0]     d_cur;
    logic [4:0]           trial;
    logic                 ge;
    logic [3:0]           rem_step;
    logic [NUM_W-1:0]     num_step;
    logic                 last_step;
    logic [ADDR_W-1:0]    wbpe, pitch_full, gobs_full, hal_full;

    function automatic logic [BLK_W-1:0] divisor(input logic [BLK_W-1:0] d);
        return (d == '0) ? BLK_W'(1) : d;
    endfunction

    function automatic logic [NUM_W-1:0] dividend(input logic [IMG_W-1:0] ext,
                                                  input logic [BLK_W-1:0] d);
        logic [31:0] e;
        e = (32'(ext) > 32'(MAX_EXTENT)) ? 32'(MAX_EXTENT) : 32'(ext);
        return NUM_W'(e + 32'(divisor(d)) - 32'd1);
    endfunction

    function automatic logic [31:0] align_up32(input logic [31:0] v, input logic [31:0] a);
        return ((v - 32'd1) | (a - 32'd1)) + 32'd1;
    endfunction

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        d_cur     = divisor((state_reg == ST_DIVH) ? block_height_reg : block_width_reg);
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = (trial >= {1'b0, d_cur});
        rem_step  = ge ? 4'(trial - {1'b0, d_cur}) : trial[3:0];
        num_step  = {num_reg[NUM_W-2:0], ge};
        last_step = (cnt_reg == CNT_W'(NUM_W - 1));
    end

    always_comb
    begin
        wbpe       = 32'(w_reg) * 32'(bpe_reg);
        pitch_full = align_up32(wbpe, tile_mode_reg ? 32'(GOB_ROW_BYTES)
                                                    : 32'(LIN_PITCH_ALIGN));
        gobs_full  = (wbpe + 32'(GOB_ROW_BYTES - 1)) >> $clog2(GOB_ROW_BYTES);
        hal_full   = tile_mode_reg ? align_up32(32'(h_reg), 32'(GOB_ROWS) << log2_reg)
                                   : 32'(h_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        pitch_next = pitch_reg;
        gobs_next  = gobs_reg;
        hal_next   = hal_reg;
        prod_next  = prod_reg;
        size_next  = size_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                num_next   = dividend(image_width_reg, block_width_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                num_next = num_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    w_next     = num_step;
                    num_next   = dividend(image_height_reg, block_height_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVH;
                end
            end
            ST_DIVH:
            begin
                num_next = num_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    h_next     = num_step;
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH:
            begin
                pitch_next = PITCH_W'(pitch_full);
                gobs_next  = GOB_W'(gobs_full);
                hal_next   = HAL_W'(hal_full);
                state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                prod_next  = 32'(pitch_reg) * 32'(hal_reg);
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                size_next  = align_up32(prod_reg, 32'(align_reg));
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            block_width_reg  <= RST_BLOCK_WIDTH;
            block_height_reg <= RST_BLOCK_HEIGHT;
            bpe_reg          <= RST_BPE;
            tile_mode_reg    <= RST_TILE_MODE;
            align_reg        <= RST_ALIGN;
            log2_reg         <= RST_BH_LOG2;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:       image_width_reg  <= cfg_wdata[IMG_W-1:0];
                    REG_IMAGE_HEIGHT:      image_height_reg <= cfg_wdata[IMG_W-1:0];
                    REG_BLOCK_WIDTH:       block_width_reg  <= cfg_wdata[BLK_W-1:0];
                    REG_BLOCK_HEIGHT_PX:   block_height_reg <= cfg_wdata[BLK_W-1:0];
                    REG_BYTES_PER_ELEMENT: bpe_reg          <= cfg_wdata[BPE_W-1:0];
                    REG_TILE_MODE:         tile_mode_reg    <= cfg_wdata[0];
                    REG_SURFACE_ALIGNMENT: align_reg        <= cfg_wdata[ALIGN_W-1:0];
                    REG_BLOCK_HEIGHT_LOG2: log2_reg         <= cfg_wdata[LOG2_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        pitch_reg <= pitch_next;
        gobs_reg  <= gobs_next;
        hal_reg   <= hal_next;
        prod_reg  <= prod_next;
        size_reg  <= size_next;
    end

    assign ctl.valid     = (state_reg == ST_IDLE);
    assign ctl.tile_mode = tile_mode_reg;
    assign ctl.bh_log2   = log2_reg;
    assign ctl.bpe       = bpe_reg;
    assign ctl.size      = size_reg;
    assign width_blk     = w_reg;
    assign pitch         = pitch_reg;
    assign gobs_wide     = gobs_reg;

endmodule

>>> rtl/block_linear_texture_address.sv
// Top level of the block-linear texture address generator: four-stage address pipeline.
// Depends on blta_pkg and blta_geom.
//
// Usage:
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is high.
//   Requests: x_coord/y_coord (element units) on in_valid/in_ready.
//   Results: src_addr (tiled surface offset), dst_addr (linear image offset) and
//   copy_ok on out_valid/out_ready, one result per request, in order.
// Path: a request passes stage A, B, C and the output stage, which drives out_valid.
// Throughput: one request per cycle; every pipeline stage advances on its own,
//   so a stalled output holds only the last stage and bubbles ahead of it close up.
// Geometry: after reset and after every configuration write the surface width,
//   pitch and size are recomputed by a one-bit-per-cycle divider over width then
//   height; in_ready stays low until the recompute is done.
// Reset: registers return to their reset values and the pipeline empties.
// Stall: with out_ready low, the result holds and in_ready drops once all four
//   stages are full.
module block_linear_texture_address #(
    parameter int MAX_EXTENT = blta_pkg::MAX_EXTENT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [blta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blta_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [blta_pkg::COORD_W-1:0]     x_coord,
    input  logic [blta_pkg::COORD_W-1:0]     y_coord,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [blta_pkg::ADDR_W-1:0]      src_addr,
    output logic [blta_pkg::ADDR_W-1:0]      dst_addr,
    output logic                             copy_ok
);
    import blta_pkg::*;

    localparam int NUM_W   = $clog2(MAX_EXTENT + 16);
    localparam int PITCH_W = NUM_W + 6;
    localparam int GOB_W   = NUM_W;
    localparam int NSTG    = 4;
    localparam int XB_W    = COORD_W + BPE_W;
    localparam int YT_W    = COORD_W - $clog2(GOB_ROWS);
    localparam int GOB_SH  = $clog2(GOB_BYTES);
    localparam int ROW_SH  = $clog2(GOB_ROW_BYTES);

    geom_ctl_t             ctl;
    logic [NUM_W-1:0]      width_blk;
    logic [PITCH_W-1:0]    pitch;
    logic [GOB_W-1:0]      gobs_wide;

    logic [NSTG-1:0]       valid_reg, valid_next;
    logic [NSTG-1:0]       en;
    logic                  in_acc;

    // stage A
    logic [COORD_W-1:0]    x_a_reg, y_a_reg;
    logic [XB_W-1:0]       xb_a_reg;
    logic [ADDR_W-1:0]     yw_a_reg, ypitch_a_reg;
    logic [YT_W-1:0]       ytile_a_reg;
    // stage B
    logic [COORD_W-1:0]    y_b_reg;
    logic [XB_W-1:0]       xb_b_reg;
    logic [ADDR_W-1:0]     src_lin_b_reg, dst_pre_b_reg, gprod_b_reg;
    // stage C
    logic [ADDR_W-1:0]     src_c_reg, dst_c_reg;
    // output stage
    logic [ADDR_W-1:0]     src_reg, dst_reg;
    logic                  ok_reg;

    logic [ADDR_W-1:0]     src_bl, tile_hi;
    logic [YT_W-1:0]       ymid;
    logic [GOB_SH-1:0]     gob_low;
    logic                  ok_c;

    blta_geom #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .width_blk (width_blk),
        .pitch     (pitch),
        .gobs_wide (gobs_wide)
    );

    // advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0] && ctl.valid;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        valid_next[0] = en[0] ? in_acc : valid_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        tile_hi = gprod_b_reg + 32'(xb_b_reg[XB_W-1:ROW_SH]);
        ymid    = (y_b_reg[COORD_W-1:$clog2(GOB_ROWS)]) & ~({YT_W{1'b1}} << ctl.bh_log2);
        gob_low = {xb_b_reg[5], y_b_reg[2:1], xb_b_reg[4], y_b_reg[0], xb_b_reg[3:0]};
        src_bl  = ((tile_hi << GOB_SH) << ctl.bh_log2) + (32'(ymid) << GOB_SH)
                  + 32'(gob_low);
        ok_c    = ((src_c_reg + 32'(ctl.bpe)) <= ctl.size)
                  && ((dst_c_reg + 32'(ctl.bpe)) <= ctl.size);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_a_reg      <= x_coord;
            y_a_reg      <= y_coord;
            xb_a_reg     <= XB_W'(x_coord) * XB_W'(ctl.bpe);
            yw_a_reg     <= 32'(y_coord) * 32'(width_blk);
            ypitch_a_reg <= 32'(y_coord) * 32'(pitch);
            ytile_a_reg  <= YT_W'(y_coord >> ($clog2(GOB_ROWS) + 32'(ctl.bh_log2)));
        end
        if (en[1])
        begin
            y_b_reg       <= y_a_reg;
            xb_b_reg      <= xb_a_reg;
            src_lin_b_reg <= ypitch_a_reg + 32'(xb_a_reg);
            dst_pre_b_reg <= yw_a_reg + 32'(x_a_reg);
            gprod_b_reg   <= 32'(ytile_a_reg) * 32'(gobs_wide);
        end
        if (en[2])
        begin
            src_c_reg <= ctl.tile_mode ? src_bl : src_lin_b_reg;
            dst_c_reg <= dst_pre_b_reg * 32'(ctl.bpe);
        end
        if (en[3])
        begin
            src_reg <= src_c_reg;
            dst_reg <= dst_c_reg;
            ok_reg  <= ok_c;
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign src_addr  = src_reg;
    assign dst_addr  = dst_reg;
    assign copy_ok   = ok_reg;

    a_ready_needs_geom: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> ctl.valid)
        else $error("request taken before geometry is ready");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("request taken during geometry recompute");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !en[0]) |=> valid_reg[0])
        else $error("stalled stage lost its request");

endmodule

>>> tb/sv/block_linear_texture_address_test.sv
`timescale 1ns / 1ps
// Self-checking test of block_linear_texture_address: pitch and block linear address
// pairs and the copy_ok bound, predicted in-line and checked per result. Needs blta_pkg.
module block_linear_texture_address_test;

    import blta_pkg::*;

    localparam int PIPE_LATENCY   = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int RANDOM_PHASES  = 25;
    localparam int STEADY_PHASE   = 12;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;

    typedef struct {
        logic [IMG_W-1:0]   width;
        logic [IMG_W-1:0]   height;
        logic [BLK_W-1:0]   blk_w;
        logic [BLK_W-1:0]   blk_h;
        logic [BPE_W-1:0]   bpe;
        logic               tiled;
        logic [ALIGN_W-1:0] align;
        logic [LOG2_W-1:0]  bh_log2;
    } surface_cfg_t;

    typedef struct {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic              ok;
    } addr_pair_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [COORD_W-1:0]    x_coord   = '0;
    logic [COORD_W-1:0]    y_coord   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ADDR_W-1:0]     src_addr;
    logic [ADDR_W-1:0]     dst_addr;
    logic                  copy_ok;

    surface_cfg_t surface_now = '{RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_BLOCK_WIDTH,
                                  RST_BLOCK_HEIGHT, RST_BPE, RST_TILE_MODE, RST_ALIGN,
                                  RST_BH_LOG2};
    addr_pair_t   pending_addrs[$];

    int mismatch_count = 0;
    int checked_count  = 0;
    int sent_count     = 0;
    int surface_count  = 0;
    int cycle_count    = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;
    int rx_hold_seq    = 0;
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;

    block_linear_texture_address DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .copy_ok   (copy_ok)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] div_ceil(logic [31:0] n, logic [31:0] d);
        logic [31:0] dd;
        dd = (d == 32'd0) ? 32'd1 : d;
        return (n + dd - 32'd1) / dd;
    endfunction

    function automatic logic [31:0] align_to(logic [31:0] v, logic [31:0] a);
        return ((v - 32'd1) | (a - 32'd1)) + 32'd1;
    endfunction

    // Width or height in elements, with the extent saturated first.
    function automatic logic [31:0] surface_extent(surface_cfg_t c, bit vertical);
        logic [31:0] px;
        logic [31:0] blk;
        px  = vertical ? 32'(c.height) : 32'(c.width);
        blk = vertical ? 32'(c.blk_h) : 32'(c.blk_w);
        if (px > 32'(MAX_EXTENT_DEF))
            px = 32'(MAX_EXTENT_DEF);
        return div_ceil(px, blk);
    endfunction

    function automatic addr_pair_t texel_addresses(surface_cfg_t c, logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
        logic [31:0] xv, yv, bpe, bh, w, h, pitch, surf_bytes, rows, xb, gobs_wide;
        logic [31:0] end_src, end_dst;
        addr_pair_t  r;
        xv  = 32'(x);
        yv  = 32'(y);
        bpe = 32'(c.bpe);
        bh  = 32'd1 << c.bh_log2;
        w   = surface_extent(c, 1'b0);
        h   = surface_extent(c, 1'b1);
        if (!c.tiled)
        begin
            pitch      = align_to(w * bpe, 32'(LIN_PITCH_ALIGN));
            surf_bytes = align_to(pitch * h, 32'(c.align));
            r.src      = yv * pitch + xv * bpe;
        end
        else
        begin
            pitch      = align_to(w * bpe, 32'(GOB_ROW_BYTES));
            rows       = 32'(GOB_ROWS) * bh;
            surf_bytes = align_to(pitch * align_to(h, rows), 32'(c.align));
            gobs_wide  = div_ceil(w * bpe, 32'(GOB_ROW_BYTES));
            xb         = xv * bpe;
            r.src = (yv / rows) * 32'(GOB_BYTES) * bh * gobs_wide
                  + (xb / 32'd64) * 32'(GOB_BYTES) * bh
                  + ((yv % rows) / 32'd8) * 32'(GOB_BYTES)
                  + ((xb % 32'd64) / 32'd32) * 32'd256
                  + ((yv % 32'd8) / 32'd2) * 32'd64
                  + ((xb % 32'd32) / 32'd16) * 32'd32
                  + (yv % 32'd2) * 32'd16
                  + (xb % 32'd16);
        end
        r.dst   = (yv * w + xv) * bpe;
        end_src = r.src + bpe;
        end_dst = r.dst + bpe;
        r.ok    = (end_src <= surf_bytes) && (end_dst <= surf_bytes);
        return r;
    endfunction

    function automatic surface_cfg_t make_surface(int w, int h, int bw, int bh, int bpe,
                                                  bit tiled, int align, int bh_log2);
        surface_cfg_t c;
        c.width   = IMG_W'(w);
        c.height  = IMG_W'(h);
        c.blk_w   = BLK_W'(bw);
        c.blk_h   = BLK_W'(bh);
        c.bpe     = BPE_W'(bpe);
        c.tiled   = tiled;
        c.align   = ALIGN_W'(align);
        c.bh_log2 = LOG2_W'(bh_log2);
        return c;
    endfunction

    function automatic logic [IMG_W-1:0] random_dimension();
        case ($urandom_range(0, 7))
            0:       return IMG_W'(1);
            1:       return IMG_W'(MAX_EXTENT_DEF);
            2:       return IMG_W'($urandom_range(MAX_EXTENT_DEF + 1, (1 << IMG_W) - 1));
            3:       return '0;
            4, 5:    return IMG_W'($urandom_range(1, 64));
            default: return IMG_W'($urandom_range(1, MAX_EXTENT_DEF));
        endcase
    endfunction

    function automatic surface_cfg_t random_surface();
        surface_cfg_t c;
        c.width   = random_dimension();
        c.height  = random_dimension();
        c.blk_w   = ($urandom_range(0, 1) == 0) ? BLK_W'(1) : BLK_W'($urandom_range(0, 15));
        c.blk_h   = ($urandom_range(0, 1) == 0) ? BLK_W'(1) : BLK_W'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       c.bpe = '0;
            1:       c.bpe = '1;
            default: c.bpe = BPE_W'($urandom_range(1, 16));
        endcase
        c.tiled = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       c.align = '0;
            1:       c.align = ALIGN_W'($urandom_range(1, (1 << ALIGN_W) - 1));
            2:       c.align = ALIGN_W'(65536);
            3:       c.align = ALIGN_W'(1);
            default: c.align = ALIGN_W'(1) << $urandom_range(0, 16);
        endcase
        c.bh_log2 = LOG2_W'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_surface(input surface_cfg_t c);
        wait_drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(c.width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.height));
        write_reg(REG_BLOCK_WIDTH, CFG_DATA_W'(c.blk_w));
        write_reg(REG_BLOCK_HEIGHT_PX, CFG_DATA_W'(c.blk_h));
        write_reg(REG_BYTES_PER_ELEMENT, CFG_DATA_W'(c.bpe));
        write_reg(REG_TILE_MODE, CFG_DATA_W'(c.tiled));
        write_reg(REG_SURFACE_ALIGNMENT, CFG_DATA_W'(c.align));
        write_reg(REG_BLOCK_HEIGHT_LOG2, CFG_DATA_W'(c.bh_log2));
        cfg_we <= 1'b0;
        surface_now = c;
        surface_count++;
    endtask

    task automatic send_request(input int x, input int y);
        if (!tx_steady && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= COORD_W'(x);
        y_coord  <= COORD_W'(y);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_addrs.insert(pending_addrs.size(),
                             texel_addresses(surface_now, COORD_W'(x), COORD_W'(y)));
        sent_count++;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endtask

    task automatic test_reset_defaults();
        send_request(0, 0);
        send_request(COORD_MAX, COORD_MAX);
        wait_drain();
    endtask

    task automatic test_pitch_linear();
        load_surface(make_surface(100, 50, 1, 1, 4, 1'b0, 512, 0));
        send_request(0, 0);
        send_request(99, 0);
        send_request(0, 49);
        send_request(99, 49);
        wait_drain();
    endtask

    task automatic test_block_linear();
        load_surface(make_surface(MAX_EXTENT_DEF, MAX_EXTENT_DEF, 4, 4, 16, 1'b1, 65536, 5));
        send_request(0, 0);
        send_request(1, 1);
        send_request(2, 3);
        send_request(3, 6);
        send_request(4095, 4095);
        send_request(COORD_MAX, COORD_MAX);
        wait_drain();
    endtask

    task automatic test_special_cases();
        // zero block size, oversized extents, tallest tile, addresses that wrap
        load_surface(make_surface(32767, 20000, 0, 0, 31, 1'b1, 1, 7));
        send_request(COORD_MAX, COORD_MAX);
        send_request(0, 0);
        // zero extents, zero element size, zero alignment
        load_surface(make_surface(0, 0, 12, 12, 0, 1'b0, 0, 0));
        send_request(0, 0);
        send_request(5, 5);
        // alignment that is not a power of two; last element and one past it
        load_surface(make_surface(33, 7, 1, 1, 3, 1'b0, 100, 3));
        send_request(32, 6);
        send_request(33, 7);
        send_request(0, 0);
        // single tile row, all-ones alignment, coordinates far outside the image
        load_surface(make_surface(1, 1, 12, 12, 1, 1'b1, (1 << ALIGN_W) - 1, 0));
        send_request(0, 0);
        send_request(COORD_MAX, 0);
        wait_drain();
    endtask

    task automatic test_output_stall();
        load_surface(random_surface());
        tx_steady = 1'b1;
        rx_hold_seq++;
        repeat (40)
            send_request(int'($urandom_range(0, COORD_MAX)),
                         int'($urandom_range(0, COORD_MAX)));
        tx_steady = 1'b0;
        wait_drain();
    endtask

    task automatic test_random();
        surface_cfg_t       c;
        int                 n_items;
        logic [31:0]        w, h;
        int                 x, y;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            c = random_surface();
            load_surface(c);
            tx_steady = (phase == STEADY_PHASE);
            rx_steady = (phase == STEADY_PHASE);
            n_items   = tx_steady ? 200 : 44;
            w = surface_extent(c, 1'b0);
            h = surface_extent(c, 1'b1);
            repeat (n_items)
            begin
                if (w != 0 && $urandom_range(0, 99) < 60)
                    x = int'($urandom_range(0, w - 1));
                else
                    x = int'($urandom_range(0, COORD_MAX));
                if (h != 0 && $urandom_range(0, 99) < 60)
                    y = int'($urandom_range(0, h - 1));
                else
                    y = int'($urandom_range(0, COORD_MAX));
                send_request(x, y);
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
        wait_drain();
    endtask

    // Receiver: random stalls, steady stretches, and a long hold on request.
    always @(posedge clk)
    begin
        if (rx_hold_seq != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_seq;
            rx_hold_left <= RX_HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready    <= 1'b0;
        end
        else if (rx_steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin : check_results
        addr_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_addrs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no result, actual src %h dst %h ok %b",
                         $time, src_addr, dst_addr, copy_ok);
            end
            else
            begin
                want = pending_addrs.pop_front();
                checked_count++;
                if (src_addr !== want.src)
                    report_mismatch("src_addr", want.src, src_addr);
                if (dst_addr !== want.dst)
                    report_mismatch("dst_addr", want.dst, dst_addr);
                if (copy_ok !== want.ok)
                    report_mismatch("copy_ok", 32'(want.ok), 32'(copy_ok));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_addrs.size());
            $display("** block_linear_texture_address: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_pitch_linear();
        test_block_linear();
        test_special_cases();
        test_output_stall();
        test_random();
        wait_drain();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        $display("Checked %0d results from %0d requests over %0d surface settings,",
                 checked_count, sent_count, surface_count);
        $display("pitch and block linear layouts, with input gaps and output stalls.");
        if (mismatch_count == 0)
            $display("** block_linear_texture_address: PASSED **");
        else
            $display("** block_linear_texture_address: FAILED **");
        $finish;
    end

endmodule
